FILE: design/crtq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the change report table queue.
// No dependencies; used by crtq_ctrl, crtq_datapath and the top level.

package crtq_pkg;

   localparam int ENTRIES = 256;
   localparam int INDEX_W = $clog2(ENTRIES);
   localparam int COUNT_W = $clog2(ENTRIES + 1);
   localparam int LIMIT_W = 26;

   localparam logic [9:0]         MS_PER_S       = 10'd1000;
   localparam logic signed [31:0] VALUE_SENTINEL = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] FULL_POWER_RAW = 32'sd255;
   localparam logic signed [31:0] FULL_POWER_PCT = 32'sd100;

   localparam logic [1:0] CLASS_SENSOR  = 2'd0;
   localparam logic [1:0] CLASS_INVALID = 2'd3;

   typedef enum logic [1:0] {
      KIND_REGISTER = 2'd0,
      KIND_UPDATE   = 2'd1,
      KIND_PEEK     = 2'd2,
      KIND_POP      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_ENTRY,
      S_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic capture;
      logic rd_item;
      logic rd_fifo_entry;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic queue_kind;
   } dp_status_type;

   function automatic logic [INDEX_W-1:0] slot_of(input logic [7:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[INDEX_W-1:0];
   endfunction

   function automatic logic [7:0] index_of(input logic [INDEX_W-1:0] slot);
      logic [31:0] wide;
      wide = 32'(slot);
      return wide[7:0];
   endfunction

endpackage

FILE: design/crtq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the change report table queue: steps one item through
// read, lookup and commit, and owns the result valid flag. Uses crtq_pkg.

module crtq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  crtq_pkg::dp_status_type dp_status,
   output crtq_pkg::cmd_type       cmd
);

   crtq_pkg::fsm_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crtq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         crtq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.rd_item = 1'b1;
               state_in    = crtq_pkg::S_READ;
            end
         end
         crtq_pkg::S_READ: begin
            // queue items need a second, dependent lookup of the head entry
            if (dp_status.queue_kind) begin
               cmd.rd_fifo_entry = 1'b1;
               state_in          = crtq_pkg::S_ENTRY;
            end else begin
               state_in = crtq_pkg::S_FINISH;
            end
         end
         crtq_pkg::S_ENTRY: begin
            state_in = crtq_pkg::S_FINISH;
         end
         crtq_pkg::S_FINISH: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = crtq_pkg::S_IDLE;
            end
         end
         default: state_in = crtq_pkg::S_IDLE;
      endcase
   end

   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == crtq_pkg::S_READ))
      else $error("accepted item did not move to read");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == crtq_pkg::S_FINISH && !cmd.commit) |=>
      (state_ff == crtq_pkg::S_FINISH && rsp_valid_ff))
      else $error("pending result lost while output busy");

endmodule

FILE: design/crtq_datapath.sv
`timescale 1ns / 1ps
// Datapath: entry stores, deduplicating index queue, repost timing and the
// result register. Driven by crtq_ctrl commands; uses crtq_pkg.

module crtq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_kind,
   input  logic [7:0]              req_entry_index,
   input  logic [1:0]              req_entry_class,
   input  logic [31:0]             req_stamp_ms,
   input  logic signed [31:0]      req_new_value,
   input  logic                    req_full_power_fix,
   input  logic                    csr_wr_en,
   input  logic [15:0]             csr_wr_data,
   input  crtq_pkg::cmd_type       cmd,
   output crtq_pkg::dp_status_type dp_status,
   output logic [1:0]              rsp_status,
   output logic                    rsp_found,
   output logic [7:0]              rsp_out_index,
   output logic [1:0]              rsp_out_class,
   output logic signed [31:0]      rsp_out_value
);

   localparam int IW = crtq_pkg::INDEX_W;
   localparam int CW = crtq_pkg::COUNT_W;
   localparam int LW = crtq_pkg::LIMIT_W;
   localparam int N  = crtq_pkg::ENTRIES;

   // memories
   logic [1:0]         class_mem [N];
   logic signed [31:0] value_mem [N];
   logic [31:0]        time_mem  [N];
   logic [IW-1:0]      fifo_mem  [N];

   logic [1:0]         class_rd_ff;
   logic signed [31:0] value_rd_ff;
   logic [31:0]        time_rd_ff;
   logic [IW-1:0]      fifo_rd_ff;

   // per-entry flags
   logic [N-1:0] registered_ff, registered_in;
   logic [N-1:0] queued_ff, queued_in;
   logic [N-1:0] time_valid_ff, time_valid_in;

   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] limit_ff;

   // captured item
   crtq_pkg::kind_type kind_ff;
   logic [7:0]         idx_ff;
   logic [1:0]         cls_ff;
   logic [31:0]        stamp_ff;
   logic signed [31:0] val_ff;
   logic signed [31:0] val_fixed;

   // result register
   crtq_pkg::status_type stat_ff, stat_in;
   logic               found_ff, found_in;
   logic [7:0]         oidx_ff, oidx_in;
   logic [1:0]         ocls_ff, ocls_in;
   logic signed [31:0] oval_ff, oval_in;

   logic [IW-1:0] idx_slot, entry_addr;
   logic          is_reg, is_upd, is_pop, queue_kind, in_range;
   logic          do_reg, do_store, do_enq, do_pop, already, full, found;
   logic [31:0]   cur_time, diff;
   logic          changed;
   logic [1:0]    cls_store;

   assign val_fixed = (req_full_power_fix && req_new_value == crtq_pkg::FULL_POWER_RAW) ?
                      crtq_pkg::FULL_POWER_PCT : req_new_value;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= crtq_pkg::kind_type'(req_kind);
         idx_ff   <= req_entry_index;
         cls_ff   <= req_entry_class;
         stamp_ff <= req_stamp_ms;
         val_ff   <= val_fixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_wr_en) begin
         limit_ff <= LW'(csr_wr_data) * LW'(crtq_pkg::MS_PER_S);
      end
   end

   assign queue_kind           = (kind_ff == crtq_pkg::KIND_PEEK) ||
                                 (kind_ff == crtq_pkg::KIND_POP);
   assign dp_status.queue_kind = queue_kind;

   // one shared read address for class and value: item entry, then queue head entry
   assign entry_addr = cmd.rd_item ? crtq_pkg::slot_of(req_entry_index) : fifo_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_item || cmd.rd_fifo_entry) begin
         class_rd_ff <= class_mem[entry_addr];
         value_rd_ff <= value_mem[entry_addr];
      end
      if (cmd.rd_item) begin
         time_rd_ff <= time_mem[crtq_pkg::slot_of(req_entry_index)];
         fifo_rd_ff <= fifo_mem[head_ff];
      end
   end

   // decision, evaluated while committing
   assign idx_slot  = crtq_pkg::slot_of(idx_ff);
   assign in_range  = 32'(idx_ff) < 32'(N);
   assign is_reg    = kind_ff == crtq_pkg::KIND_REGISTER;
   assign is_upd    = kind_ff == crtq_pkg::KIND_UPDATE;
   assign is_pop    = kind_ff == crtq_pkg::KIND_POP;
   assign cur_time  = time_valid_ff[idx_slot] ? time_rd_ff : 32'd0;
   assign diff      = stamp_ff - cur_time;
   assign changed   = (val_ff != value_rd_ff) || (diff > 32'(limit_ff));
   assign already   = queued_ff[idx_slot];
   assign full      = count_ff == CW'(N);
   assign found     = count_ff != '0;
   assign cls_store = (cls_ff == crtq_pkg::CLASS_INVALID) ? crtq_pkg::CLASS_SENSOR : cls_ff;

   assign do_reg   = cmd.commit && is_reg && in_range;
   assign do_store = cmd.commit && is_upd && in_range && registered_ff[idx_slot] && changed;
   assign do_enq   = do_store && !already && !full;
   assign do_pop   = cmd.commit && is_pop && found;

   always_ff @(posedge clock) begin
      if (do_reg) begin
         class_mem[idx_slot] <= cls_store;
      end
      if (do_reg || do_store) begin
         value_mem[idx_slot] <= do_reg ? crtq_pkg::VALUE_SENTINEL : val_ff;
      end
      if (do_store) begin
         time_mem[idx_slot] <= stamp_ff;
      end
      if (do_enq) begin
         fifo_mem[tail_ff] <= idx_slot;
      end
   end

   always_comb begin
      registered_in = registered_ff;
      queued_in     = queued_ff;
      time_valid_in = time_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      if (do_reg) begin
         registered_in[idx_slot] = 1'b1;
      end
      if (do_store) begin
         time_valid_in[idx_slot] = 1'b1;
      end
      if (do_enq) begin
         queued_in[idx_slot] = 1'b1;
         tail_in  = (tail_ff == IW'(N - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (do_pop) begin
         queued_in[fifo_rd_ff] = 1'b0;
         head_in  = (head_ff == IW'(N - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         registered_ff <= '0;
         queued_ff     <= '0;
         time_valid_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
      end else begin
         registered_ff <= registered_in;
         queued_ff     <= queued_in;
         time_valid_ff <= time_valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
      end
   end

   // result
   always_comb begin
      stat_in  = crtq_pkg::STAT_OK;
      found_in = 1'b0;
      oidx_in  = '0;
      ocls_in  = '0;
      oval_in  = '0;
      priority if ((is_reg || is_upd) && !in_range) begin
         stat_in = crtq_pkg::STAT_RANGE;
      end else if (do_store && !already && full) begin
         stat_in = crtq_pkg::STAT_FULL;
      end else if (queue_kind && found) begin
         found_in = 1'b1;
         oidx_in  = crtq_pkg::index_of(fifo_rd_ff);
         ocls_in  = registered_ff[fifo_rd_ff] ? class_rd_ff : 2'd0;
         oval_in  = registered_ff[fifo_rd_ff] ? value_rd_ff : 32'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         stat_ff  <= stat_in;
         found_ff <= found_in;
         oidx_ff  <= oidx_in;
         ocls_ff  <= ocls_in;
         oval_ff  <= oval_in;
      end
   end

   assign rsp_status    = stat_ff;
   assign rsp_found     = found_ff;
   assign rsp_out_index = oidx_ff;
   assign rsp_out_class = ocls_ff;
   assign rsp_out_value = oval_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N))
      else $error("queue count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_pop_unmarks: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> !queued_ff[$past(fifo_rd_ff)])
      else $error("popped entry still marked as queued");

endmodule

FILE: design/change_report_table_queue.sv
`timescale 1ns / 1ps
// Change report table queue: report-by-exception table with dedup index queue.
// Register/update items step through read and finish; peek/pop add an entry lookup.
// One item in flight: a new item is taken only after the last commits, which waits on
// a stalled output; peek/pop chain two reads on the entry stores' single read port.
// Reset (synchronous): marks, time valid bits, queue pointers and timeout clear at once.
// Depends on crtq_pkg, crtq_ctrl and crtq_datapath.

module change_report_table_queue (
   input  logic               clock,
   input  logic               reset,
   // item input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_entry_index,
   input  logic [1:0]         req_entry_class,
   input  logic [31:0]        req_stamp_ms,
   input  logic signed [31:0] req_new_value,
   input  logic               req_full_power_fix,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic [7:0]         rsp_out_index,
   output logic [1:0]         rsp_out_class,
   output logic signed [31:0] rsp_out_value,
   // repost timeout in seconds
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   crtq_pkg::cmd_type       cmd;
   crtq_pkg::dp_status_type dp_status;

   // Sequencer: idle -> read (item entry + queue head) -> [entry lookup] -> finish.
   // The result register frees the input side: a new item can be accepted while
   // the previous result is still stalled at the output.
   crtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // Stores, queue and compare logic; every table and queue update lands on commit.
   crtq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_kind),
      .req_entry_index    (req_entry_index),
      .req_entry_class    (req_entry_class),
      .req_stamp_ms       (req_stamp_ms),
      .req_new_value      (req_new_value),
      .req_full_power_fix (req_full_power_fix),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .cmd                (cmd),
      .dp_status          (dp_status),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_out_index      (rsp_out_index),
      .rsp_out_class      (rsp_out_class),
      .rsp_out_value      (rsp_out_value)
   );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for change_report_table_queue: directed and random items
// checked against an in-bench mirror of the entry table and its index queue.
// Depends on crtq_pkg and the change_report_table_queue RTL.

module tb;

   localparam int CYCLE_LIMIT = 400000;   // watchdog limit for the whole run
   localparam int MAX_SHOWN   = 10;       // mismatches printed in full, the rest only counted

   // One item as offered on the request side
   typedef struct {
      crtq_pkg::kind_type kind;
      logic [7:0]         index;
      logic [1:0]         cls;
      logic [31:0]        stamp;
      logic signed [31:0] value;
      logic               fix;
   } table_item_type;

   // One result as seen on the response side
   typedef struct {
      logic [1:0]         status;
      logic               found;
      logic [7:0]         index;
      logic [1:0]         cls;
      logic signed [31:0] value;
   } table_rsp_type;

   // Mirror of the entry table and the dedup index queue. Each accepted item
   // updates the mirror and leaves the result it should cause in awaited_results.
   class report_table_mirror_type;
      bit                 registered  [crtq_pkg::ENTRIES];
      bit [1:0]           entry_class [crtq_pkg::ENTRIES];
      bit [31:0]          entry_value [crtq_pkg::ENTRIES];
      bit [31:0]          reported_at [crtq_pkg::ENTRIES];
      bit                 queued      [crtq_pkg::ENTRIES];
      logic [7:0]         index_queue [$];
      logic [15:0]        timeout_s;
      table_rsp_type      awaited_results [$];
      int                 mismatches;

      function void note_item(table_item_type it);
         table_rsp_type    want;
         logic [31:0]      v;
         logic [31:0]      age;
         logic [7:0]       e;
         longint unsigned  span;
         want = '{default: '0};
         want.status = crtq_pkg::STAT_OK;
         unique case (it.kind)
            crtq_pkg::KIND_REGISTER: begin
               if (int'(it.index) >= crtq_pkg::ENTRIES) begin
                  want.status = crtq_pkg::STAT_RANGE;
               end else begin
                  registered[it.index]  = 1'b1;
                  entry_class[it.index] = (it.cls == crtq_pkg::CLASS_INVALID) ?
                                          crtq_pkg::CLASS_SENSOR : it.cls;
                  entry_value[it.index] = crtq_pkg::VALUE_SENTINEL;
               end
            end
            crtq_pkg::KIND_UPDATE: begin
               if (int'(it.index) >= crtq_pkg::ENTRIES) begin
                  want.status = crtq_pkg::STAT_RANGE;
               end else if (registered[it.index]) begin
                  v    = (it.fix && it.value == crtq_pkg::FULL_POWER_RAW) ?
                         crtq_pkg::FULL_POWER_PCT : it.value;
                  age  = it.stamp - reported_at[it.index];   // wraps modulo 2^32
                  span = longint'(timeout_s) * longint'(crtq_pkg::MS_PER_S);
                  if (v != entry_value[it.index] || longint'(age) > span) begin
                     entry_value[it.index] = v;
                     reported_at[it.index] = it.stamp;
                     if (!queued[it.index]) begin
                        if (index_queue.size() >= crtq_pkg::ENTRIES) begin
                           want.status = crtq_pkg::STAT_FULL;
                        end else begin
                           index_queue.push_back(it.index);
                           queued[it.index] = 1'b1;
                        end
                     end
                  end
               end
            end
            default: begin   // peek or pop
               if (index_queue.size() != 0) begin
                  e          = index_queue[0];
                  want.found = 1'b1;
                  want.index = e;
                  want.cls   = entry_class[e];
                  want.value = entry_value[e];
                  if (it.kind == crtq_pkg::KIND_POP) begin
                     void'(index_queue.pop_front());
                     queued[e] = 1'b0;
                  end
               end
            end
         endcase
         awaited_results.push_back(want);
      endfunction

      function void report_bad(string what, table_rsp_type want, table_rsp_type got);
         mismatches++;
         if (mismatches <= MAX_SHOWN) begin
            $display("%t %s: expected st %0d fd %0d idx %0d cls %0d val %0d",
                     $realtime, what, want.status, want.found, want.index, want.cls,
                     want.value);
            $display("   got st %0d fd %0d idx %0d cls %0d val %0d",
                     got.status, got.found, got.index, got.cls, got.value);
         end
      endfunction

      function void check_result(table_rsp_type got);
         table_rsp_type want;
         if (awaited_results.size() == 0) begin
            report_bad("result with nothing pending", '{default: '0}, got);
         end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.found !== want.found ||
                got.index !== want.index || got.cls !== want.cls || got.value !== want.value)
               report_bad("result mismatch", want, got);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_kind;
   logic [7:0]         req_entry_index;
   logic [1:0]         req_entry_class;
   logic [31:0]        req_stamp_ms;
   logic signed [31:0] req_new_value;
   logic               req_full_power_fix;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic               rsp_found;
   logic [7:0]         rsp_out_index;
   logic [1:0]         rsp_out_class;
   logic signed [31:0] rsp_out_value;
   logic               csr_wr_en;
   logic [15:0]        csr_wr_data;

   report_table_mirror_type board = new();
   bit                 quiet_run;     // no idling on either side while set
   int unsigned        cycles;

   change_report_table_queue DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_entry_index    (req_entry_index),
      .req_entry_class    (req_entry_class),
      .req_stamp_ms       (req_stamp_ms),
      .req_new_value      (req_new_value),
      .req_full_power_fix (req_full_power_fix),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_out_index      (rsp_out_index),
      .rsp_out_class      (rsp_out_class),
      .rsp_out_value      (rsp_out_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall = !quiet_run && ($urandom_range(99) < 16);
   end

   // Result monitor, sampled on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result('{rsp_status, rsp_found, rsp_out_index, rsp_out_class,
                              rsp_out_value});
   end

   // Every field random; callers override what matters
   function automatic table_item_type random_item(crtq_pkg::kind_type kind);
      table_item_type it;
      it.kind  = kind;
      it.index = 8'($urandom_range(255));
      it.cls   = 2'($urandom_range(3));
      it.stamp = $urandom;
      it.value = $urandom;
      it.fix   = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic table_item_type make_item(crtq_pkg::kind_type kind, logic [7:0] index,
                                                logic [1:0] cls, logic [31:0] stamp,
                                                logic signed [31:0] value, logic fix);
      table_item_type it;
      it = '{kind, index, cls, stamp, value, fix};
      return it;
   endfunction

   // Offer one item; returns on the falling edge after it was taken.
   // Called and returning on a falling edge.
   task automatic send_item(table_item_type it);
      while (!quiet_run && $urandom_range(99) < 16) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_kind           = it.kind;
      req_entry_index    = it.index;
      req_entry_class    = it.cls;
      req_stamp_ms       = it.stamp;
      req_new_value      = it.value;
      req_full_power_fix = it.fix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(it);
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding result, plus the block's latency
   task automatic hold_until_drained();
      req_valid = 1'b0;
      while (board.awaited_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Timeout register is only touched while the block is idle
   task automatic set_repost_timeout(logic [15:0] secs);
      hold_until_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = secs;
      @(negedge clock);
      csr_wr_en = 1'b0;
      board.timeout_s = secs;
   endtask

   // Short hand-picked sequence: empty queue, class folding, full-power fix,
   // strict repost boundary, wrapped time, sentinel value and re-registration.
   task automatic run_directed();
      // timeout is 2 s here, so the repost boundary is 2000 ms
      send_item(make_item(crtq_pkg::KIND_POP,  8'd0,  2'd0, 32'd0, 32'sd0, 1'b0));
      send_item(make_item(crtq_pkg::KIND_PEEK, 8'hFF, 2'd3, '1,    -32'sd1, 1'b1));
      send_item(make_item(crtq_pkg::KIND_UPDATE, 8'd5, 2'd0, 32'd10, 32'sd7, 1'b0));
      // the update above hits an unregistered entry
      send_item(make_item(crtq_pkg::KIND_REGISTER, 8'd0,   2'd1, 32'd0, 32'sd0, 1'b0));
      send_item(make_item(crtq_pkg::KIND_REGISTER, 8'd255, 2'd3, 32'd0, 32'sd0, 1'b0));
      send_item(make_item(crtq_pkg::KIND_REGISTER, 8'd128, 2'd2, 32'd0, 32'sd0, 1'b0));
      // 255 -> 100, then unchanged, exactly on the boundary, one past it
      send_item(make_item(crtq_pkg::KIND_UPDATE, 8'd0, 2'd0, 32'd1000, 32'sd255, 1'b1));
      send_item(make_item(crtq_pkg::KIND_UPDATE, 8'd0, 2'd0, 32'd1500, 32'sd100, 1'b0));
      send_item(make_item(crtq_pkg::KIND_UPDATE, 8'd0, 2'd0, 32'd3000, 32'sd100, 1'b0));
      send_item(make_item(crtq_pkg::KIND_UPDATE, 8'd0, 2'd0, 32'd3001, 32'sd100, 1'b0));
      send_item(make_item(crtq_pkg::KIND_UPDATE, 8'd255, 2'd0, 32'hFFFF_FFF0,
                          32'sh8000_0000, 1'b1));
      send_item(make_item(crtq_pkg::KIND_UPDATE, 8'd255, 2'd0, 32'h0000_0100,
                          32'sh8000_0000, 1'b0));                          // wrapped, short
      send_item(make_item(crtq_pkg::KIND_UPDATE, 8'd128, 2'd0, 32'd5,
                          crtq_pkg::VALUE_SENTINEL, 1'b0));
      send_item(make_item(crtq_pkg::KIND_UPDATE, 8'd128, 2'd0, 32'd6, 32'sd255, 1'b0));
      send_item(make_item(crtq_pkg::KIND_PEEK,     8'd0,   2'd0, 32'd0, 32'sd0, 1'b0));
      send_item(make_item(crtq_pkg::KIND_POP,      8'd0,   2'd0, 32'd0, 32'sd0, 1'b0));
      send_item(make_item(crtq_pkg::KIND_REGISTER, 8'd255, 2'd0, 32'd0, 32'sd0, 1'b0));
      send_item(make_item(crtq_pkg::KIND_POP,      8'd0,   2'd0, 32'd0, 32'sd0, 1'b0));
      send_item(make_item(crtq_pkg::KIND_POP,      8'd0,   2'd0, 32'd0, 32'sd0, 1'b0));
      send_item(make_item(crtq_pkg::KIND_POP,      8'd0,   2'd0, 32'd0, 32'sd0, 1'b0));
      send_item(make_item(crtq_pkg::KIND_UPDATE,   8'd0,   2'd0, '1,   -32'sd1, 1'b1));
      send_item(make_item(crtq_pkg::KIND_PEEK,     8'd0,   2'd0, 32'd0, 32'sd0, 1'b0));
   endtask

   // Mostly well-formed traffic on a handful of hot entries, so that values
   // repeat, indices dedup and stamps land on the repost boundary; a little noise.
   task automatic run_mixed(int count);
      logic [7:0]     hot [8];
      table_item_type it;
      logic [31:0]    lim;
      int             r;
      for (int k = 0; k < 8; k++) hot[k] = 8'($urandom_range(255));
      for (int n = 0; n < count; n++) begin
         lim = 32'(board.timeout_s) * 32'(crtq_pkg::MS_PER_S);
         r   = $urandom_range(99);
         if (r < 5) begin
            it = random_item(crtq_pkg::kind_type'($urandom_range(3)));      // noise
         end else if (r < 17) begin
            it = random_item(crtq_pkg::KIND_REGISTER);
            it.index = hot[$urandom_range(7)];
         end else if (r < 67) begin
            it = random_item(crtq_pkg::KIND_UPDATE);
            it.index = hot[$urandom_range(7)];
            r = $urandom_range(99);
            if (r < 45)
               it.stamp = board.reported_at[it.index] + 32'($urandom_range(200));
            else if (r < 75)   // just below, on or just past the boundary
               it.stamp = board.reported_at[it.index] + lim + 32'($urandom_range(2)) - 32'd1;
            else if (r < 90)
               it.stamp = board.reported_at[it.index] + lim + $urandom_range(1000000);
            r = $urandom_range(99);
            if (r < 45)      it.value = board.entry_value[it.index];
            else if (r < 60) it.value = crtq_pkg::FULL_POWER_RAW;
            else if (r < 70) it.value = crtq_pkg::FULL_POWER_PCT;
            else if (r < 85) it.value = 32'($urandom_range(7)) - 32'sd3;
         end else if (r < 80) begin
            it = random_item(crtq_pkg::KIND_PEEK);
         end else begin
            it = random_item(crtq_pkg::KIND_POP);
         end
         send_item(it);
      end
   endtask

   // Register and report every entry so the queue runs completely full, then empty it
   task automatic run_fill();
      table_item_type it;
      for (int i = 0; i < crtq_pkg::ENTRIES; i++) begin
         it = random_item(crtq_pkg::KIND_REGISTER);
         it.index = 8'(i);
         send_item(it);
      end
      for (int i = 0; i < crtq_pkg::ENTRIES; i++) begin
         it = random_item(crtq_pkg::KIND_UPDATE);
         it.index = 8'(i);
         if (it.value == crtq_pkg::VALUE_SENTINEL) it.value = 32'sd0;
         send_item(it);
      end
      while (board.index_queue.size() != 0)
         send_item(random_item(crtq_pkg::kind_type'(($urandom_range(99) < 80) ?
                                  crtq_pkg::KIND_POP : crtq_pkg::KIND_PEEK)));
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_kind           = crtq_pkg::KIND_REGISTER;
      req_entry_index    = '0;
      req_entry_class    = '0;
      req_stamp_ms       = '0;
      req_new_value      = '0;
      req_full_power_fix = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      quiet_run          = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_repost_timeout(16'd2);
      run_directed();

      // long stretch with no idling on either side, zero timeout
      set_repost_timeout(16'd0);
      quiet_run = 1'b1;
      run_mixed(230);
      quiet_run = 1'b0;

      // largest timeout; sender holds off mid-phase until all results are in
      set_repost_timeout(16'hFFFF);
      run_mixed(115);
      hold_until_drained();
      run_mixed(115);

      set_repost_timeout(16'($urandom_range(1, 10)));
      run_fill();

      set_repost_timeout(16'd1);
      run_mixed(230);

      set_repost_timeout(16'($urandom_range(16'hFFFF)));
      run_mixed(230);

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.awaited_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
design/crtq_pkg.sv
design/crtq_ctrl.sv
design/crtq_datapath.sv
design/change_report_table_queue.sv
test/tb.sv
